FILE: design/ms_pkg.sv
// ----------------------------------------------------------------------------
// ms_pkg: shared definitions for the merge sorter.
// Sizes of the element buffers and the one-hot sequencer state codes.
// ----------------------------------------------------------------------------
package ms_pkg;

	// Capacity of one set and width of one element.
	localparam int MAX_ITEMS  = 64;
	localparam int DATA_WIDTH = 32;

	// Index width addresses the buffers; count width also holds MAX_ITEMS.
	localparam int IDX_W = $clog2(MAX_ITEMS);
	localparam int CNT_W = IDX_W + 1;

	// Sequencer states, one-hot.
	typedef enum logic [10:0] {
		ST_LOAD     = 11'b000_0000_0001,
		ST_START    = 11'b000_0000_0010,
		ST_NEXT     = 11'b000_0000_0100,
		ST_RDA      = 11'b000_0000_1000,
		ST_RDB      = 11'b000_0001_0000,
		ST_HEADB    = 11'b000_0010_0000,
		ST_CMP      = 11'b000_0100_0000,
		ST_FILL     = 11'b000_1000_0000,
		ST_OUT_RD   = 11'b001_0000_0000,
		ST_OUT_LD   = 11'b010_0000_0000,
		ST_OUT_HOLD = 11'b100_0000_0000
	} state_t;

endpackage

FILE: design/ms_ram.sv
// ----------------------------------------------------------------------------
// ms_ram: generic simple dual-port RAM.
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module ms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/merge_sorter.sv
// ----------------------------------------------------------------------------
// merge_sorter: buffered ascending sort of signed values.
// Loads a set of signed values and emits them in ascending order.
// ----------------------------------------------------------------------------
// Values arrive one per transfer on the slave stream and are stored, one cycle
// each, up to 64 per set; further values are discarded and every result of
// that set then carries tuser = 1. The transfer with tlast set ends the set:
// the block drops tready, sorts by stable bottom-up merge passes (ties keep
// input order) and sends the sorted run on the master stream with tlast on its
// final element. The sort runs through one shared comparator and one read port
// of two ping-pong buffers, and there are ceil(log2(N)) passes for N elements.
// Each result is read from the buffer, registered, and held on the master
// stream until it is taken; only then is the next one read. The next set is
// accepted once the last result of the run has been transferred.
// ----------------------------------------------------------------------------
module merge_sorter (
	input  logic        clk,
	input  logic        arst_n,
	// Slave stream: tdata = value[31:0]; tlast = last_item.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        s_tlast,
	// Master stream: tdata = sorted_value[31:0]; tlast = last_out; tuser = dropped.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	output logic        m_tlast,
	output logic        m_tuser
);

	localparam int IDX_W = ms_pkg::IDX_W;
	localparam int CNT_W = ms_pkg::CNT_W;
	localparam int DW    = ms_pkg::DATA_WIDTH;

	ms_pkg::state_t state_q;

	logic [CNT_W-1:0] count_q;
	logic             overflow_q;
	logic             src_sel_q;
	logic [CNT_W-1:0] width_q;
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] mid_q;
	logic [CNT_W-1:0] hi_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] j_q;
	logic [CNT_W-1:0] k_q;
	logic             fill_b_q;
	logic signed [DW-1:0] a_q;
	logic signed [DW-1:0] b_q;

	logic [DW-1:0] out_data_q;
	logic          out_last_q;
	logic          out_valid_q;

	logic                 in_xfer;
	logic                 has_room;
	logic                 a_ok;
	logic                 b_ok;
	logic                 take_a;
	logic                 merge_wr;
	logic [DW-1:0]        merge_data;
	logic [CNT_W-1:0]     width2;
	logic [CNT_W-1:0]     lo_plus_w;
	logic [CNT_W-1:0]     lo_plus_2w;
	logic [CNT_W-1:0]     i_next;
	logic [CNT_W-1:0]     j_next;
	logic [IDX_W-1:0]     raddr;
	logic                 we0;
	logic                 we1;
	logic [IDX_W-1:0]     waddr0;
	logic [DW-1:0]        wdata0;
	logic [DW-1:0]        rdata0;
	logic [DW-1:0]        rdata1;
	logic signed [DW-1:0] src_data;

	assign s_tready = (state_q == ms_pkg::ST_LOAD);
	assign in_xfer  = s_tvalid && s_tready;
	assign has_room = (count_q < CNT_W'(ms_pkg::MAX_ITEMS));

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = overflow_q;

	// Merge compare: heads of the left and right runs, left wins on ties.
	assign a_ok       = (i_q < mid_q);
	assign b_ok       = (j_q < hi_q);
	assign take_a     = a_ok && (!b_ok || (a_q <= b_q));
	assign merge_wr   = (state_q == ms_pkg::ST_CMP) && (a_ok || b_ok);
	assign merge_data = take_a ? a_q : b_q;
	assign i_next     = i_q + CNT_W'(1);
	assign j_next     = j_q + CNT_W'(1);

	// Run bounds of the next merge.
	assign width2     = {width_q[CNT_W-2:0], 1'b0};
	assign lo_plus_w  = lo_q + width_q;
	assign lo_plus_2w = lo_q + width2;

	// Shared read address of the source buffer.
	always_comb begin
		case (state_q)
			ms_pkg::ST_RDA:    raddr = i_q[IDX_W-1:0];
			ms_pkg::ST_RDB:    raddr = j_q[IDX_W-1:0];
			ms_pkg::ST_CMP:    raddr = take_a ? i_next[IDX_W-1:0] : j_next[IDX_W-1:0];
			ms_pkg::ST_OUT_RD: raddr = k_q[IDX_W-1:0];
			default:           raddr = k_q[IDX_W-1:0];
		endcase
	end

	// Buffer 0 takes loaded values and results of even passes; buffer 1 the rest.
	assign we0    = (in_xfer && has_room) || (merge_wr && src_sel_q);
	assign waddr0 = s_tready ? count_q[IDX_W-1:0] : k_q[IDX_W-1:0];
	assign wdata0 = s_tready ? s_tdata : merge_data;
	assign we1    = merge_wr && !src_sel_q;

	assign src_data = src_sel_q ? rdata1 : rdata0;

	ms_ram #(
		.WIDTH (DW),
		.DEPTH (ms_pkg::MAX_ITEMS)
	) u_store (
		.clk   (clk),
		.we    (we0),
		.waddr (waddr0),
		.wdata (wdata0),
		.raddr (raddr),
		.rdata (rdata0)
	);

	ms_ram #(
		.WIDTH (DW),
		.DEPTH (ms_pkg::MAX_ITEMS)
	) u_scratch (
		.clk   (clk),
		.we    (we1),
		.waddr (k_q[IDX_W-1:0]),
		.wdata (merge_data),
		.raddr (raddr),
		.rdata (rdata1)
	);

	// Sequencer: load, merge passes, then output of the sorted run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ms_pkg::ST_LOAD;
			count_q     <= '0;
			overflow_q  <= 1'b0;
			src_sel_q   <= 1'b0;
			out_valid_q <= 1'b0;
			width_q     <= '0;
			lo_q        <= '0;
			mid_q       <= '0;
			hi_q        <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			fill_b_q    <= 1'b0;
		end else begin
			case (state_q)
				ms_pkg::ST_LOAD: begin
					if (in_xfer) begin
						if (has_room) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							overflow_q <= 1'b1;
						end
						if (s_tlast) begin
							state_q <= ms_pkg::ST_START;
						end
					end
				end
				ms_pkg::ST_START: begin
					src_sel_q <= 1'b0;
					width_q   <= CNT_W'(1);
					lo_q      <= '0;
					k_q       <= '0;
					if (count_q <= CNT_W'(1)) begin
						state_q <= ms_pkg::ST_OUT_RD;
					end else begin
						state_q <= ms_pkg::ST_NEXT;
					end
				end
				ms_pkg::ST_NEXT: begin
					if (lo_q >= count_q) begin
						// Pass complete: swap buffers and double the run width.
						src_sel_q <= !src_sel_q;
						width_q   <= width2;
						lo_q      <= '0;
						k_q       <= '0;
						if (width2 >= count_q) begin
							state_q <= ms_pkg::ST_OUT_RD;
						end
					end else begin
						mid_q   <= (lo_plus_w < count_q) ? lo_plus_w : count_q;
						hi_q    <= (lo_plus_2w < count_q) ? lo_plus_2w : count_q;
						i_q     <= lo_q;
						j_q     <= (lo_plus_w < count_q) ? lo_plus_w : count_q;
						k_q     <= lo_q;
						state_q <= ms_pkg::ST_RDA;
					end
				end
				ms_pkg::ST_RDA: begin
					state_q <= ms_pkg::ST_RDB;
				end
				ms_pkg::ST_RDB: begin
					a_q     <= src_data;
					state_q <= ms_pkg::ST_HEADB;
				end
				ms_pkg::ST_HEADB: begin
					b_q     <= src_data;
					state_q <= ms_pkg::ST_CMP;
				end
				ms_pkg::ST_CMP: begin
					if (!a_ok && !b_ok) begin
						lo_q    <= lo_plus_2w;
						state_q <= ms_pkg::ST_NEXT;
					end else begin
						k_q <= k_q + CNT_W'(1);
						if (take_a) begin
							i_q      <= i_next;
							fill_b_q <= 1'b0;
							if (i_next < mid_q) begin
								state_q <= ms_pkg::ST_FILL;
							end
						end else begin
							j_q      <= j_next;
							fill_b_q <= 1'b1;
							if (j_next < hi_q) begin
								state_q <= ms_pkg::ST_FILL;
							end
						end
					end
				end
				ms_pkg::ST_FILL: begin
					if (fill_b_q) begin
						b_q <= src_data;
					end else begin
						a_q <= src_data;
					end
					state_q <= ms_pkg::ST_CMP;
				end
				ms_pkg::ST_OUT_RD: begin
					state_q <= ms_pkg::ST_OUT_LD;
				end
				ms_pkg::ST_OUT_LD: begin
					out_data_q  <= src_data;
					out_last_q  <= (k_q + CNT_W'(1) >= count_q);
					out_valid_q <= 1'b1;
					state_q     <= ms_pkg::ST_OUT_HOLD;
				end
				ms_pkg::ST_OUT_HOLD: begin
					if (m_tready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							count_q    <= '0;
							overflow_q <= 1'b0;
							state_q    <= ms_pkg::ST_LOAD;
						end else begin
							k_q     <= k_q + CNT_W'(1);
							state_q <= ms_pkg::ST_OUT_RD;
						end
					end
				end
				default: begin
					state_q <= ms_pkg::ST_LOAD;
				end
			endcase
		end
	end

	// The block never loads while a result is on offer.
	assert property (@(posedge clk) disable iff (!arst_n) !(s_tready && m_tvalid))
		else $error("input accepted while a result is pending");

	// The fill count never passes the capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ms_pkg::MAX_ITEMS))
		else $error("fill count beyond capacity");

	// During a merge, every element written came from one of the two runs.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ms_pkg::ST_CMP) |-> (k_q + mid_q == i_q + j_q))
		else $error("merge output index out of step with run heads");

	// After the final result of a run, the block returns to loading.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
		else $error("block did not return to loading after the run");

endmodule

FILE: verif/merge_sorter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merge_sorter_tb: self-checking testbench for the merge sorter.
// Sends sets of signed values on the slave stream. A software sort predicts
// each sorted run, and every master transfer is checked field by field.
// ----------------------------------------------------------------------------
// A short table of directed sets comes first. Single-value sets carry their
// expected result in the table. Random sets of mixed size follow, some
// overflowing the store. Both streams idle at random. The receiver holds off
// once for a long stretch while the sender keeps offering, and the sender
// drains the block twice before going on.
// ----------------------------------------------------------------------------
module merge_sorter_tb;

	localparam int ITEM_TARGET = 360;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 8000;
	localparam int SETTLE_CYCLES = 50;

	// One sorted element as it should appear on the master stream.
	typedef struct packed {
		logic [31:0] value;
		logic        last;
		logic        dropped;
	} sorted_t;

	// One directed input; typed rows carry the single expected value.
	typedef struct packed {
		logic [31:0] value;
		logic        last;
		logic        typed;
		logic [31:0] exp_value;
	} dir_row_t;

	localparam int DIR_ROWS = 14;

	dir_row_t dir_rows [0:DIR_ROWS-1] = '{
		// Single-value sets: the value comes straight back as the whole run.
		'{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
		'{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
		'{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
		'{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
		// Mixed set with a tie and both extremes.
		'{32'd5,         1'b0, 1'b0, 32'h0},
		'{32'hFFFF_FFFD, 1'b0, 1'b0, 32'h0},
		'{32'd5,         1'b0, 1'b0, 32'h0},
		'{32'h8000_0000, 1'b0, 1'b0, 32'h0},
		'{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
		'{32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
		// Two values in descending order.
		'{32'd1,         1'b0, 1'b0, 32'h0},
		'{32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
		// Two equal values.
		'{32'd7,         1'b0, 1'b0, 32'h0},
		'{32'd7,         1'b1, 1'b0, 32'h0}
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // value[31:0]
	logic        s_tlast;   // last_item
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // sorted_value[31:0]
	logic        m_tlast;   // last_out
	logic        m_tuser;   // dropped

	// Predictor state: the set being loaded and the runs still to arrive.
	logic signed [31:0] load_buf [ms_pkg::MAX_ITEMS];
	int                 load_count;
	bit                 load_drop;
	sorted_t            sorted_q [$];
	sorted_t            head;

	// Directed row details for the item now on the slave stream.
	bit          row_typed;
	logic [31:0] row_exp;

	bit hold_request;
	bit calm;
	int errors;
	int items_sent;
	int quiet;
	int sets_done;
	int results_seen;
	int overflow_sets;
	int longest_set;

	merge_sorter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Idle length: mostly none or short, now and then long; none in calm sets.
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Random element: extremes, small values that tie often, or any pattern.
	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 32'h8000_0000;
		if (r == 1)
			return 32'h7FFF_FFFF;
		if (r < 5)
			return 32'($urandom_range(0, 15)) - 32'd8;
		return $urandom();
	endfunction

	// Store one accepted value; on the last one sort the set and queue its run.
	task automatic absorb_value(input logic [31:0] v, input logic lst);
		logic signed [31:0] key;
		int                 j;
		int                 k;
		if (load_count < ms_pkg::MAX_ITEMS) begin
			load_buf[load_count] = v;
			load_count++;
		end else begin
			load_drop = 1'b1;
		end
		if (lst) begin
			// Insertion sort moves only strictly greater values, so ties keep order.
			for (k = 1; k < load_count; k++) begin
				key = load_buf[k];
				j = k - 1;
				while (j >= 0 && load_buf[j] > key) begin
					load_buf[j + 1] = load_buf[j];
					j--;
				end
				load_buf[j + 1] = key;
			end
			if (row_typed) begin
				sorted_q.push_back(sorted_t'{row_exp, 1'b1, 1'b0});
			end else begin
				for (k = 0; k < load_count; k++)
					sorted_q.push_back(sorted_t'{load_buf[k], k == load_count - 1,
						load_drop});
			end
			sets_done++;
			if (load_drop)
				overflow_sets++;
			if (load_count > longest_set)
				longest_set = load_count;
			load_count = 0;
			load_drop = 1'b0;
		end
	endtask

	// Offer one value and wait for its transfer.
	task automatic send_value(input logic [31:0] v, input logic lst);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = v;
		s_tlast = lst;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		items_sent++;
	endtask

	// Stop offering until every queued result has been transferred.
	task automatic drain_results();
		s_tvalid = 1'b0;
		while (sorted_q.size() != 0)
			@(negedge clk);
	endtask

	// Check both streams at each rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				absorb_value(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (sorted_q.size() == 0) begin
					$error("result %h with no value expected", m_tdata);
					errors++;
				end else begin
					head = sorted_q.pop_front();
					if (m_tdata !== head.value) begin
						$error("sorted_value: expected %h, got %h", head.value, m_tdata);
						errors++;
					end
					if (m_tlast !== head.last) begin
						$error("last_out: expected %b, got %b", head.last, m_tlast);
						errors++;
					end
					if (m_tuser !== head.dropped) begin
						$error("dropped: expected %b, got %b", head.dropped, m_tuser);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog: end the run if no transfer happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= QUIET_LIMIT) begin
					$display("[merge_sorter] ERROR");
					$finish;
				end
			end
		end
	end

	// Receiver: bursts of ready with random stalls, plus one long hold-off.
	initial begin
		int burst;
		int gap;
		m_tready = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_request && m_tvalid) begin
				hold_request = 1'b0;
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				m_tready = 1'b1;
				burst = $urandom_range(1, 16);
				repeat (burst) begin
					@(negedge clk);
					if (hold_request && m_tvalid)
						break;
				end
				gap = idle_gap();
				if (gap > 0 && !(hold_request && m_tvalid)) begin
					m_tready = 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
		end
	end

	// Sender: directed table, then random sets.
	initial begin
		int set_idx;
		int set_size;
		int k;
		int r;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		arst_n = 1'b0;
		row_typed = 1'b0;
		row_exp = '0;
		hold_request = 1'b0;
		calm = 1'b0;
		load_count = 0;
		load_drop = 1'b0;
		errors = 0;
		items_sent = 0;
		quiet = 0;
		sets_done = 0;
		results_seen = 0;
		overflow_sets = 0;
		longest_set = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		for (k = 0; k < DIR_ROWS; k++) begin
			row_typed = dir_rows[k].typed;
			row_exp = dir_rows[k].exp_value;
			send_value(dir_rows[k].value, dir_rows[k].last);
		end
		row_typed = 1'b0;
		drain_results();

		// Random sets: a full set under a long receiver hold, then an overflow.
		set_idx = 0;
		while (items_sent < ITEM_TARGET) begin
			r = $urandom_range(0, 9);
			if (set_idx == 0) begin
				set_size = ms_pkg::MAX_ITEMS;
				hold_request = 1'b1;
			end else if (set_idx == 1) begin
				set_size = ms_pkg::MAX_ITEMS + 3;
			end else if (r < 7) begin
				set_size = $urandom_range(1, 12);
			end else if (r == 7) begin
				set_size = $urandom_range(13, 40);
			end else if (r == 8) begin
				set_size = ms_pkg::MAX_ITEMS;
			end else begin
				set_size = $urandom_range(ms_pkg::MAX_ITEMS + 1, ms_pkg::MAX_ITEMS + 6);
			end
			calm = ($urandom_range(0, 3) == 0);
			for (k = 0; k < set_size; k++)
				send_value(pick_value(), k == set_size - 1);
			set_idx++;
			if (set_idx == 8)
				drain_results();
		end
		calm = 1'b0;
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Sorted %0d sets from %0d values into %0d results.",
			sets_done, items_sent, results_seen);
		$display("Largest set held %0d values; %0d sets overflowed the store.",
			longest_set, overflow_sets);
		if (errors == 0)
			$display("[merge_sorter] OK");
		else
			$display("[merge_sorter] ERROR");
		$finish;
	end

endmodule

FILE: merge_sorter.f
design/ms_pkg.sv
design/ms_ram.sv
design/merge_sorter.sv
verif/merge_sorter_tb.sv
